### design/htwd_pkg.sv
// Shared types and constants for the Huffman tree-walk decoder.
// No dependencies; imported by the top level.
`default_nettype none

package htwd_pkg;

  localparam int SYM_W    = 12;
  localparam int CHILD_W  = 13;
  localparam int PARENT_W = 12;
  localparam int DICT_W   = 13;

  localparam logic [DICT_W-1:0] DICT_RESET = 13'd256;
  localparam logic [DICT_W-1:0] DICT_MIN   = 13'd2;
  localparam logic [DICT_W-1:0] DICT_MAX   = 13'd4096;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LINK   = 2'd1,
    OP_DECODE = 2'd2
  } opcode_t;

  // The alphabet size in use, held to the supported range.
  function automatic logic [DICT_W-1:0] eff_dict(input logic [DICT_W-1:0] d);
    logic [DICT_W-1:0] r;
    if (d < DICT_MIN) begin
      r = DICT_MIN;
    end else if (d > DICT_MAX) begin
      r = DICT_MAX;
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### design/htwd_node_ram.sv
// Node table storage: simple dual-port RAM, one write and one registered read.
// No dependencies.
`default_nettype none

module htwd_node_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 28
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### design/huffman_tree_walk_decoder.sv
// Huffman tree-walk decoder: top level with sequencer, walk step and output register.
// Depends on htwd_pkg and htwd_node_ram.
//
// The decoder keeps a Huffman tree as a table of internal nodes, each with two
// child slots, and walks it one code bit at a time. A clear request empties the
// whole table and puts the walk at the root entry (the alphabet size in effect
// minus two); it sweeps the table one entry per cycle, and the same sweep runs
// right after reset (configuration writes are still taken during it). A link
// request is accepted, the parent entry is read, and the merged entry is
// written back if the link is in range. A decode request walks its WORD_BITS
// code bits least significant bit first, one bit per cycle while the output
// does not stall it. Each step needs the entry chosen by the previous step,
// and the node table read data is registered. Every leaf reached produces
// one symbol; the last symbol of a word carries last_of_word. Walking into an
// empty slot sends the walk back to the root without producing a symbol. The
// block takes one request at a time and holds req_stall high while it works.
// The newest symbol is held back until the next one is found or the word ends,
// so that the end-of-word mark can be attached to it; results sit in an output
// register, so a new request can be accepted while a symbol still waits.
`default_nettype none

module huffman_tree_walk_decoder
  import htwd_pkg::*;
#(
  parameter int TABLE_DEPTH = 4096,
  parameter int WORD_BITS   = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration: alphabet size.
  input  wire logic                 dict_we,
  input  wire logic [DICT_W-1:0]    dict_wdata,
  // Request channel.
  input  wire logic                 req_valid,
  output logic                      req_stall,
  input  wire logic [1:0]           opcode,
  input  wire logic [CHILD_W-1:0]   child_number,
  input  wire logic [PARENT_W-1:0]  parent_index,
  input  wire logic [WORD_BITS-1:0] code_word,
  input  wire logic                 stream_start,
  // Symbol channel.
  output logic                      sym_valid,
  input  wire logic                 sym_stall,
  output logic [SYM_W-1:0]          symbol,
  output logic                      last_of_word
);

  // Table address width, width of a stored node value (symbol or entry),
  // width of one slot {valid, leaf, value} and of one entry (two slots).
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int VW = (AW > SYM_W) ? AW : SYM_W;
  localparam int SW = VW + 2;
  localparam int EW = 2 * SW;
  localparam int CW = $clog2(WORD_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLR,
    S_LRD,
    S_LWR,
    S_PRIME,
    S_WALK,
    S_FLUSH
  } state_t;

  state_t state;

  logic [DICT_W-1:0]    dict_size;
  logic [AW-1:0]        clr_addr;
  logic [VW-1:0]        current_node;
  logic [WORD_BITS-1:0] word_sh;
  logic [CW-1:0]        bit_cnt;
  logic                 pend_valid;
  logic [SYM_W-1:0]     pend_sym;

  // Link request captured at acceptance.
  logic [AW-1:0]        lk_parent;
  logic                 lk_leaf;
  logic [VW-1:0]        lk_val;
  logic                 lk_ok;

  // Node table ports.
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [EW-1:0]        mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;
  logic [EW-1:0]        rd_data;

  htwd_node_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW),
    .DW    (EW)
  ) u_node_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // Alphabet size in effect and the root entry it implies.
  logic [DICT_W-1:0]  eff_d;
  logic [VW-1:0]      root_node;
  logic               child_leaf;
  logic [CHILD_W-1:0] child_int;
  logic               link_ok;

  assign eff_d      = eff_dict(dict_size);
  assign root_node  = VW'(eff_d - DICT_MIN);
  assign child_leaf = (child_number < eff_d);
  assign child_int  = child_number - eff_d;
  assign link_ok    = (int'(parent_index) < TABLE_DEPTH) &&
                      (child_leaf || (int'(child_int) < TABLE_DEPTH));

  // One walk step: choose the slot named by the current code bit.
  logic [SW-1:0] slot_sel;
  logic          sel_valid;
  logic          sel_leaf;
  logic [VW-1:0] sel_val;
  logic          node_oor;
  logic          hit;
  logic          leaf_hit;
  logic [VW-1:0] next_node;
  logic          out_busy;
  logic          step_ok;

  assign slot_sel  = word_sh[0] ? rd_data[EW-1:SW] : rd_data[SW-1:0];
  assign sel_valid = slot_sel[SW-1];
  assign sel_leaf  = slot_sel[SW-2];
  assign sel_val   = slot_sel[VW-1:0];
  assign node_oor  = (int'(current_node) >= TABLE_DEPTH);
  assign hit       = !node_oor && sel_valid;
  assign leaf_hit  = hit && sel_leaf;
  assign next_node = (hit && !sel_leaf) ? sel_val : root_node;
  assign out_busy  = sym_valid && sym_stall;
  // A leaf found while an older symbol is pending pushes that symbol out,
  // which needs the output register to be free.
  assign step_ok   = !(leaf_hit && pend_valid && out_busy);

  // Merged entry for a link: the first link fills slot 0, later ones slot 1.
  logic [SW-1:0] new_slot;
  logic [EW-1:0] merged;

  assign new_slot = {1'b1, lk_leaf, lk_val};
  assign merged   = rd_data[SW-1] ? {new_slot, rd_data[SW-1:0]}
                                  : {rd_data[EW-1:SW], new_slot};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = current_node[AW-1:0];
    unique case (state)
      S_CLR: begin
        mem_we = 1'b1;
      end
      S_LRD: begin
        mem_re    = 1'b1;
        mem_raddr = lk_parent;
      end
      S_LWR: begin
        mem_we    = lk_ok;
        mem_waddr = lk_parent;
        mem_wdata = merged;
      end
      S_PRIME: begin
        mem_re = 1'b1;
      end
      S_WALK: begin
        mem_re    = step_ok;
        mem_raddr = next_node[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      clr_addr     <= '0;
      dict_size    <= DICT_RESET;
      current_node <= VW'(DICT_RESET - DICT_MIN);
      pend_valid   <= 1'b0;
      sym_valid    <= 1'b0;
      bit_cnt      <= '0;
    end else begin
      if (dict_we) begin
        dict_size <= dict_wdata;
      end
      if (sym_valid && !sym_stall) begin
        sym_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            case (opcode)
              OP_CLEAR: begin
                clr_addr     <= '0;
                current_node <= root_node;
                state        <= S_CLR;
              end
              OP_LINK: begin
                lk_parent <= AW'(parent_index);
                lk_leaf   <= child_leaf;
                lk_val    <= child_leaf ? VW'(child_number) : VW'(child_int);
                lk_ok     <= link_ok;
                state     <= S_LRD;
              end
              OP_DECODE: begin
                if (stream_start) begin
                  current_node <= root_node;
                end
                word_sh <= code_word;
                bit_cnt <= '0;
                state   <= S_PRIME;
              end
              default: begin
              end
            endcase
          end
        end
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_LRD: begin
          state <= S_LWR;
        end
        S_LWR: begin
          state <= S_IDLE;
        end
        S_PRIME: begin
          state <= S_WALK;
        end
        S_WALK: begin
          if (step_ok) begin
            if (leaf_hit) begin
              if (pend_valid) begin
                sym_valid    <= 1'b1;
                symbol       <= pend_sym;
                last_of_word <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_sym   <= sel_val[SYM_W-1:0];
            end
            current_node <= next_node;
            word_sh      <= word_sh >> 1;
            bit_cnt      <= bit_cnt + 1'b1;
            if (bit_cnt == CW'(WORD_BITS - 1)) begin
              state <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (!out_busy) begin
            sym_valid    <= 1'b1;
            symbol       <= pend_sym;
            last_of_word <= 1'b1;
            pend_valid   <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A symbol held back for the end-of-word mark never outlives its word.
  a_pend_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("pending symbol left over after a decode word");

  // A clear request always starts a full sweep from the first entry.
  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && opcode == OP_CLEAR) |=>
      (state == S_CLR && clr_addr == '0))
    else $error("clear request did not start the table sweep");

  // The table is never written while a word is being walked.
  a_no_write_walk: assert property (@(posedge clk) disable iff (rst)
    (state == S_PRIME || state == S_WALK || state == S_FLUSH) |-> !mem_we)
    else $error("node table written during a decode walk");

  // After a step the walk is at a table entry or back at the root.
  a_node_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && step_ok) |=>
      ((int'(current_node) < TABLE_DEPTH) || current_node == root_node))
    else $error("walk moved outside the node table");

endmodule

`default_nettype wire
